/* rtl/core/gap_buffer_text_store_unit_assert.svh */
// Assertion macros used by the gap buffer text store RTL.
`ifndef GAP_BUFFER_TEXT_STORE_UNIT_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define GBTS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gap buffer check failed");

// The consequent must hold in the same cycle as the antecedent.
`define GBTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap buffer check failed");

`endif

/* rtl/core/gbts_pkg.sv */
// Shared widths, codes and defaults of the gap buffer text store.
`timescale 1ns / 1ps
`default_nettype none

package gbts_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int MODE_W   = 1;
    localparam int POS_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 11;

    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/gap_buffer_text_store_unit.sv */
// Top level of the gap buffer text store: control sequencer, gap move engine and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "gap_buffer_text_store_unit_assert.svh"

//  Channel  | Handshake           | Payload
//  ---------+---------------------+-----------------------------
//  in       | in_valid, in_stall  | mode, position, char_in
//  out      | out_valid, out_stall| status, char_out, text_len
//
// A read passes through the fetch and done states, a refused insert (full or out of range) goes
// straight to the done state, and an insert moves the gap, writes the byte in the put state and then
// waits in done; the move is skipped when the gap already starts there and copies one byte per cycle.
// Reset clears the gap to the whole store; the memory itself is not cleared.
// A new item is taken while a finished result still waits in the output register,
// which then holds the next result back in the done state until the register frees.

module gap_buffer_text_store_unit #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [gbts_pkg::MODE_W-1:0]   mode,
    input  wire logic [gbts_pkg::POS_W-1:0]    position,
    input  wire logic [gbts_pkg::CHAR_W-1:0]   char_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [gbts_pkg::STATUS_W-1:0] status,
    output logic      [gbts_pkg::CHAR_W-1:0]   char_out,
    output logic      [gbts_pkg::LEN_W-1:0]    text_len
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOVE  = 5'b00010,
        S_PUT   = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     gb_reg, gb_next;
    logic [CW-1:0]     gs_reg, gs_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     dst_reg, dst_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              back_reg, back_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    status_t           res_status_reg, res_status_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CHAR_W-1:0]   char_out_reg;
    logic [LEN_W-1:0]    text_len_reg;
    logic                out_load;

    logic [CW-1:0]     len_c;
    logic [XW-1:0]     pos_x, len_x, gb_x, gs_x;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] rd_data;

    gbts_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign len_c = CW'(CAPACITY) - gs_reg;
    assign pos_x = XW'(position);
    assign len_x = XW'(len_c);
    assign gb_x  = XW'(gb_reg);
    assign gs_x  = XW'(gs_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        gb_next         = gb_reg;
        gs_next         = gs_reg;
        rem_next        = rem_reg;
        wr_pend_next    = 1'b0;
        src_next        = src_reg;
        dst_next        = dst_reg;
        wr_addr_next    = wr_addr_reg;
        back_next       = back_reg;
        pos_next        = pos_reg;
        ch_next         = ch_reg;
        res_status_next = res_status_reg;
        res_char_next   = res_char_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = rd_data;
        ram_raddr       = src_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next      = AW'(position);
                    ch_next       = char_in;
                    res_char_next = '0;
                    if (mode == MODE_INSERT)
                    begin
                        if (gs_reg == '0)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else if (pos_x > len_x)
                        begin
                            res_status_next = STATUS_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_status_next = STATUS_OK;
                            if (pos_x < gb_x)
                            begin
                                // Move the gap down: copy the tail end first.
                                back_next  = 1'b1;
                                rem_next   = CW'(gb_x - pos_x);
                                src_next   = AW'(gb_reg - CW'(1));
                                dst_next   = AW'(gb_reg + gs_reg - CW'(1));
                                state_next = S_MOVE;
                            end
                            else if (pos_x > gb_x)
                            begin
                                back_next  = 1'b0;
                                rem_next   = CW'(pos_x - gb_x);
                                src_next   = AW'(gb_reg + gs_reg);
                                dst_next   = AW'(gb_reg);
                                state_next = S_MOVE;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                    end
                    else
                    begin
                        if (pos_x >= len_x)
                        begin
                            res_status_next = STATUS_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_status_next = STATUS_OK;
                            ram_raddr       = (pos_x < gb_x) ? AW'(pos_x) : AW'(pos_x + gs_x);
                            state_next      = S_FETCH;
                        end
                    end
                end
            end
            S_MOVE:
            begin
                // Each write lands in the cycle after its matching read, once the read data is registered.
                if (rem_reg != '0)
                begin
                    ram_raddr    = src_reg;
                    src_next     = back_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                    dst_next     = back_reg ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));
                    rem_next     = rem_reg - CW'(1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = dst_reg;
                end
                else
                begin
                    state_next = S_PUT;
                end
                if (wr_pend_reg)
                begin
                    ram_we = 1'b1;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = ch_reg;
                gb_next    = CW'(pos_reg) + CW'(1);
                gs_next    = gs_reg - CW'(1);
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                res_char_next = rd_data;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gb_reg      <= '0;
            gs_reg      <= CW'(CAPACITY);
            rem_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gb_reg      <= gb_next;
            gs_reg      <= gs_next;
            rem_reg     <= rem_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        wr_addr_reg    <= wr_addr_next;
        back_reg       <= back_next;
        pos_reg        <= pos_next;
        ch_reg         <= ch_next;
        res_status_reg <= res_status_next;
        res_char_reg   <= res_char_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The gap size is already updated when the result is loaded.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= res_status_reg;
            char_out_reg <= res_char_reg;
            text_len_reg <= LEN_W'(len_c);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign char_out  = char_out_reg;
    assign text_len  = text_len_reg;

    `GBTS_ASSERT_ALWAYS(a_gap_in_store, ((CW+1)'(gb_reg) + (CW+1)'(gs_reg)) <= (CW+1)'(CAPACITY))
    `GBTS_ASSERT_IMP(a_write_only_when_editing, ram_we, (state_reg == S_MOVE) || (state_reg == S_PUT))
    `GBTS_ASSERT_IMP(a_move_drains_last_write, (state_reg == S_MOVE) && (rem_reg == '0), wr_pend_reg)
    `GBTS_ASSERT_NEXT(a_put_shrinks_gap, state_reg == S_PUT, gs_reg == ($past(gs_reg) - CW'(1)))

endmodule

`default_nettype wire

/* rtl/core/gbts_ram.sv */
// Text storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbts_ram #(
    parameter int DEPTH = gbts_pkg::CAPACITY_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [gbts_pkg::CHAR_W-1:0] wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [gbts_pkg::CHAR_W-1:0] rdata
);
    import gbts_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
